### sv/pdh_pkg.sv
package pdh_pkg;
	localparam int NUM_BINS = 256;
	localparam int BIN_W = 8;
	localparam int POS_BITS = 24;

	typedef enum logic [1:0] {
		OP_PAIR  = 2'd0,
		OP_SWEEP = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	localparam logic [1:0] REG_CUTOFF = 2'd0;
	localparam logic [1:0] REG_SCALE  = 2'd1;
	localparam logic [1:0] REG_BINS   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_BIN,
		ST_RMW,
		ST_CLEAR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic bin_calc;
		logic rd_issue;
		logic wr_back;
		logic clr_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       hit;
		logic       cmp_done;
		logic       sqrt_done;
		logic       clr_done;
		logic       init_busy;
	} sts_t;
endpackage

### sv/pair_distance_histogram.sv
// Pair distance histogram. One item at a time. A pair within cutoff goes through
// load and compare, the bit-serial square root, bin mapping and a histogram
// read-modify-write; pairs outside cutoff and sweep items go through load and
// compare only; bin reads add a histogram read; a clear walks all 256 bins, one
// per cycle. The next item can be taken in the cycle after the result is. After
// reset a clearing pass over all 256 bins runs; items are held off until it
// finishes. The result is held in an output register until taken.
module pair_distance_histogram (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, first_real,
	// second_real, count_particle, bin_index, zero pad
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bin_count, particle_count, sweep_count, pair_hit, hit_bin, zero pad
	output logic [127:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [51:0]  cfg_data
);
	import pdh_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy, in_fire, out_fire;
	logic [31:0] bc, sc;
	logic [47:0] pc;
	logic ph;
	logic [7:0] hb;

	assign s_tready = !busy && !sts.init_busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	pdh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
	);

	pdh_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.opcode(s_tdata[1:0]),
		.pa_x(s_tdata[25:2]), .pa_y(s_tdata[49:26]), .pa_z(s_tdata[73:50]),
		.pb_x(s_tdata[97:74]), .pb_y(s_tdata[121:98]), .pb_z(s_tdata[145:122]),
		.first_real(s_tdata[146]), .second_real(s_tdata[147]),
		.count_particle(s_tdata[148]), .bin_index(s_tdata[156:149]),
		.bin_count(bc), .particle_count(pc), .sweep_count(sc),
		.pair_hit(ph), .hit_bin(hb)
	);

	assign m_tdata = {7'd0, hb, ph, sc, pc, bc};
endmodule

### sv/pdh_ctrl.sv
module pdh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_fire,
	input  pdh_pkg::sts_t sts,
	output pdh_pkg::cmd_t cmd,
	output logic          busy,
	output logic          out_valid
);
	import pdh_pkg::*;

	state_t state_q, state_nx;
	logic   rd_wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_wait_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rd_wait_q <= (state_q == ST_RMW) && !rd_wait_q;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) state_nx = ST_SQRT;
			ST_SQRT: begin
				// wait for the cutoff compare before branching
				if (!sts.cmp_done) state_nx = ST_SQRT;
				else if (sts.op == OP_CLEAR) state_nx = ST_CLEAR;
				else if (sts.op == OP_READ) state_nx = ST_RMW;
				else if (sts.op != OP_PAIR || !sts.hit) state_nx = ST_OUT;
				else if (sts.sqrt_done) state_nx = ST_BIN;
			end
			ST_BIN:   state_nx = ST_RMW;
			ST_RMW:   if (rd_wait_q) state_nx = ST_OUT;
			ST_CLEAR: if (sts.clr_done) state_nx = ST_OUT;
			ST_OUT:   if (out_fire) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		case (state_q)
			ST_SQRT:  cmd.sqrt_step = sts.cmp_done && (sts.op == OP_PAIR) && sts.hit
			                          && !sts.sqrt_done;
			ST_BIN:   cmd.bin_calc = 1'b1;
			ST_RMW: begin
				cmd.rd_issue = !rd_wait_q;
				cmd.wr_back  = rd_wait_q && (sts.op == OP_PAIR);
				cmd.out_load = rd_wait_q;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.out_load = sts.clr_done;
			end
			default: ;
		endcase
		// non-memory items load output on leaving SQRT
		if (state_q == ST_SQRT && sts.cmp_done && sts.op != OP_CLEAR && sts.op != OP_READ
		    && (sts.op != OP_PAIR || !sts.hit))
			cmd.out_load = 1'b1;
	end

	assign busy      = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
endmodule

### sv/pdh_dp.sv
module pdh_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pdh_pkg::cmd_t         cmd,
	output pdh_pkg::sts_t         sts,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic [51:0]           cfg_data,
	input  logic [1:0]            opcode,
	input  logic signed [pdh_pkg::POS_BITS-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z,
	input  logic                  first_real,
	input  logic                  second_real,
	input  logic                  count_particle,
	input  logic [7:0]            bin_index,
	output logic [31:0]           bin_count,
	output logic [47:0]           particle_count,
	output logic [31:0]           sweep_count,
	output logic                  pair_hit,
	output logic [7:0]            hit_bin
);
	import pdh_pkg::*;

	logic [51:0] cutoff_q;
	logic [31:0] scale_q;
	logic [8:0]  nbins_q;
	logic [47:0] ptot_q;
	logic [31:0] stot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= 52'd16777216;
			scale_q  <= 32'd65536;
			nbins_q  <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CUTOFF: cutoff_q <= cfg_data;
				REG_SCALE:  scale_q  <= cfg_data[31:0];
				REG_BINS:   nbins_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// squared distance, registered per axis
	logic [POS_BITS:0]    ax, ay, az;
	logic [2*POS_BITS-1:0] sqx_q, sqy_q, sqz_q;
	logic [1:0] op_q;
	logic       inc_a_q, inc_b_q, cnt_q;
	logic [7:0] idx_q;
	logic       d2_ok_q;
	logic       sq_vld_q;

	function automatic logic [POS_BITS:0] absd(input logic signed [POS_BITS-1:0] a,
		input logic signed [POS_BITS-1:0] b);
		logic signed [POS_BITS:0] d;
		d = {b[POS_BITS-1], b} - {a[POS_BITS-1], a};
		return d[POS_BITS] ? -d : d;
	endfunction

	assign ax = absd(pa_x, pb_x);
	assign ay = absd(pa_y, pb_y);
	assign az = absd(pa_z, pb_z);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sqx_q   <= ax * ax;
			sqy_q   <= ay * ay;
			sqz_q   <= az * az;
			op_q    <= opcode;
			inc_a_q <= first_real;
			inc_b_q <= second_real;
			cnt_q   <= count_particle;
			idx_q   <= bin_index;
		end
	end

	// isqrt: one result bit per cycle
	logic [51:0] rem_q;
	logic [25:0] root_q;
	logic [4:0]  it_q;
	logic [49:0] d2;
	logic [27:0] trial;

	assign d2 = {2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_vld_q <= 1'b0;
		else sq_vld_q <= cmd.load ? 1'b0 : 1'b1;
	end

	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			it_q <= 5'd0;
		end else if (!sq_vld_q) begin
			d2_ok_q <= {2'b0, d2} < cutoff_q;
			rem_q   <= '0;
			root_q  <= '0;
			it_q    <= 5'd0;
		end else if (cmd.sqrt_step) begin
			// bring down two bits of d2
			logic [27:0] part;
			part = {rem_q[25:0], d2[49 - 2*it_q -: 2]};
			if (part >= trial) begin
				rem_q  <= 52'(part - trial);
				root_q <= {root_q[24:0], 1'b1};
			end else begin
				rem_q  <= 52'(part);
				root_q <= {root_q[24:0], 1'b0};
			end
			it_q <= it_q + 5'd1;
		end
	end

	assign sts.op        = op_q;
	assign sts.hit       = d2_ok_q && sq_vld_q;
	assign sts.cmp_done  = sq_vld_q;
	assign sts.sqrt_done = (it_q == 5'd25);

	// bin calculation
	logic [57:0] prod;
	logic [41:0] braw;
	logic [7:0]  bin_q;
	logic [8:0]  nb;

	assign prod = {32'd0, root_q} * {26'd0, scale_q};
	assign braw = prod[57:16];
	assign nb   = (nbins_q == 9'd0) ? 9'd1 : (nbins_q > 9'(NUM_BINS) ? 9'(NUM_BINS) : nbins_q);

	always_ff @(posedge clk) begin
		if (cmd.bin_calc)
			bin_q <= (braw > {33'd0, nb - 9'd1}) ? 8'(nb - 9'd1) : braw[7:0];
	end

	// histogram memory with clear sweep
	logic [31:0] mem [NUM_BINS];
	logic [31:0] rd_q;
	logic [BIN_W:0] clr_q;
	logic [BIN_W-1:0] addr;
	logic [32:0] sum;

	assign addr = (op_q == OP_READ) ? idx_q : bin_q;
	assign sum  = {1'b0, rd_q} + {32'd0, inc_a_q} + {32'd0, inc_b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + 1'b1;
		else if (cmd.load) clr_q <= (opcode == OP_CLEAR) ? '0 : clr_q;
	end

	logic rst_clr_q;
	logic [BIN_W:0] rclr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_clr_q <= 1'b1;
			rclr_q    <= '0;
		end else if (rst_clr_q) begin
			rclr_q <= rclr_q + 1'b1;
			if (rclr_q == (BIN_W+1)'(NUM_BINS - 1)) rst_clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rst_clr_q) mem[rclr_q[BIN_W-1:0]] <= '0;
		else if (cmd.clr_step) mem[clr_q[BIN_W-1:0]] <= '0;
		else if (cmd.wr_back) mem[addr] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		if (cmd.rd_issue) rd_q <= mem[addr];
	end

	assign sts.clr_done  = (clr_q == (BIN_W+1)'(NUM_BINS - 1));
	assign sts.init_busy = rst_clr_q;

	// counters and output register
	logic pair_q;
	assign pair_q = (op_q == OP_PAIR) && d2_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptot_q <= '0;
			stot_q <= '0;
		end else if (cmd.out_load) begin
			if (op_q == OP_PAIR && cnt_q && ptot_q != '1) ptot_q <= ptot_q + 48'd1;
			if (op_q == OP_SWEEP && stot_q != '1) stot_q <= stot_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bin_count <= (op_q == OP_READ) ? rd_q : 32'd0;
			pair_hit  <= pair_q;
			hit_bin   <= pair_q ? bin_q : 8'd0;
		end
	end

	assign particle_count = ptot_q;
	assign sweep_count    = stot_q;
endmodule
